FILE: rtl/core/pdca_pkg.sv
// Shared types and constants for the PWM duty-cycle capture averager.
// Used by pdca_ctrl, pdca_dp and pwm_duty_capture_averager; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdca_pkg;

  localparam int unsigned AVG_LOG2_DEF   = 3;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned FIELD_W = 16;
  localparam logic [FIELD_W-1:0] FULL_SCALE_RST = 16'd1000;
  localparam logic [FIELD_W-1:0] OUT_MAX        = 16'hFFFF;

  // APB map: 32-bit data bus; the full-scale register is selected by paddr[2] == 0
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0]  REG_FULL_SCALE = 1'b0;

  typedef struct packed {
    logic [FIELD_W-1:0] falling_capture;
    logic [FIELD_W-1:0] rising_capture;
    logic               pin_level;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] duty_value;
    logic [FIELD_W-1:0] avg_high;
    logic [FIELD_W-1:0] avg_period;
  } out_item_t;

  // controller -> datapath / output stage
  typedef struct packed {
    logic cap_load;
    logic ref_set;
    logic diff_en;
    logic adj_en;
    logic acc_en;
    logic avg_load;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic have_ref;
    logic batch_last;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pdca_ctrl.sv
// Sequencing FSM for the duty-cycle averager: capture, difference, adjust, accumulate,
// average, multiply, the iterative divide and the output load. Uses pdca_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none

module pdca_ctrl #(
  parameter int unsigned COUNT_BITS = pdca_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pdca_pkg::stat_t stat,
  input  wire logic          out_free,
  output pdca_pkg::cmd_t     cmd
);

  localparam int unsigned DIV_STEPS = pdca_pkg::FIELD_W + COUNT_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_ADJ,
    S_ACC,
    S_AVG,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_load = 1'b1;
          state_nxt    = S_DIFF;
        end
      end
      S_DIFF: begin
        if (stat.have_ref) begin
          cmd.diff_en = 1'b1;
          state_nxt   = S_ADJ;
        end else begin
          cmd.ref_set = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ADJ: begin
        cmd.adj_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = stat.batch_last ? S_AVG : S_IDLE;
      end
      S_AVG: begin
        cmd.avg_load = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_div_follows_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> cmd.div_step)
    else $error("divide did not start after operand load");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap_load, cmd.ref_set, cmd.diff_en, cmd.adj_en, cmd.acc_en,
              cmd.avg_load, cmd.div_init, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath command in a cycle");

endmodule

`default_nettype wire

FILE: rtl/core/pdca_dp.sv
// Datapath for the duty-cycle averager: capture registers, modular differences,
// running sums, multiply and a restoring divider. Driven by pdca_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module pdca_dp #(
  parameter int unsigned AVG_LOG2   = pdca_pkg::AVG_LOG2_DEF,
  parameter int unsigned COUNT_BITS = pdca_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pdca_pkg::cmd_t                cmd,
  input  wire pdca_pkg::in_item_t            in_item,
  input  wire logic [pdca_pkg::FIELD_W-1:0]  full_scale,
  output pdca_pkg::stat_t                    stat,
  output pdca_pkg::out_item_t                result
);

  localparam int unsigned FW        = pdca_pkg::FIELD_W;
  localparam int unsigned CB        = COUNT_BITS;
  localparam int unsigned SUM_W     = CB + AVG_LOG2;
  localparam int unsigned CNT_W     = AVG_LOG2 + 1;
  localparam int unsigned BATCH_LEN = 1 << AVG_LOG2;
  localparam int unsigned DW        = FW + CB;

  logic [CB-1:0]    fall_r, rise_r, last_rise_r;
  logic             pin_r, have_ref_r;
  logic [CB-1:0]    hd_r, pd_r, high_r;
  logic [SUM_W-1:0] hsum_r, psum_r;
  logic [CNT_W-1:0] count_r;
  logic [CB-1:0]    ah_r, ap_r;
  logic [DW-1:0]    quo_r;
  logic [CB:0]      rem_r;

  logic [DW-1:0]    prod;
  logic [CB:0]      rem_sh;
  logic             rem_ge;
  logic [31:0]      ah_ext, ap_ext;

  assign stat.have_ref   = have_ref_r;
  assign stat.batch_last = (count_r == CNT_W'(BATCH_LEN - 1));

  assign prod   = DW'(full_scale) * DW'(ah_r);
  // one restoring step per cycle; remainder stays below the divisor
  assign rem_sh = {rem_r[CB-1:0], quo_r[DW-1]};
  assign rem_ge = (rem_sh >= {1'b0, ap_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r  <= 1'b0;
      last_rise_r <= '0;
      count_r     <= '0;
      hsum_r      <= '0;
      psum_r      <= '0;
    end else begin
      if (cmd.ref_set) begin
        have_ref_r  <= 1'b1;
        last_rise_r <= rise_r;
      end
      if (cmd.diff_en) begin
        last_rise_r <= rise_r;
      end
      if (cmd.acc_en) begin
        hsum_r  <= hsum_r + SUM_W'(high_r);
        psum_r  <= psum_r + SUM_W'(pd_r);
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.avg_load) begin
        have_ref_r <= 1'b0;
        hsum_r     <= '0;
        psum_r     <= '0;
        count_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_load) begin
      fall_r <= CB'(in_item.falling_capture);
      rise_r <= CB'(in_item.rising_capture);
      pin_r  <= in_item.pin_level;
    end
    if (cmd.diff_en) begin
      hd_r <= fall_r - last_rise_r;
      pd_r <= rise_r - last_rise_r;
    end
    if (cmd.adj_en) begin
      // high time at or past the period: clamp if pin high, else wrap back
      if (hd_r >= pd_r) begin
        high_r <= pin_r ? pd_r : (hd_r - pd_r);
      end else begin
        high_r <= hd_r;
      end
    end
    if (cmd.avg_load) begin
      ah_r <= hsum_r[SUM_W-1:AVG_LOG2];
      ap_r <= psum_r[SUM_W-1:AVG_LOG2];
    end
    if (cmd.div_init) begin
      quo_r <= prod;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DW-2:0], rem_ge};
      rem_r <= rem_ge ? (rem_sh - {1'b0, ap_r}) : rem_sh;
    end
  end

  assign ah_ext = 32'(ah_r);
  assign ap_ext = 32'(ap_r);

  always_comb begin
    if (ap_r == '0) begin
      result.duty_value = full_scale;
    end else if (quo_r > DW'(full_scale)) begin
      result.duty_value = full_scale;
    end else begin
      result.duty_value = quo_r[FW-1:0];
    end
    result.avg_high   = (ah_ext > 32'(pdca_pkg::OUT_MAX)) ? pdca_pkg::OUT_MAX
                                                          : ah_ext[FW-1:0];
    result.avg_period = (ap_ext > 32'(pdca_pkg::OUT_MAX)) ? pdca_pkg::OUT_MAX
                                                          : ap_ext[FW-1:0];
  end

  a_batch_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.avg_load |=> (hsum_r == '0 && psum_r == '0 && count_r == '0 && !have_ref_r))
    else $error("batch state not cleared after averaging");

endmodule

`default_nettype wire

FILE: rtl/core/pwm_duty_capture_averager.sv
// A batch-closing request runs difference, adjust, accumulate, average, multiply
// and the one-bit-per-cycle divider. Input stalls while any request is in work;
// the batch-closing one blocks input until its result enters the output register.
// Reset (rst_n, synchronous): full_scale returns to 1000, sums and reference
// clear, output invalid. Top level: APB register, output register, ctrl + dp.
`timescale 1ns / 1ps
`default_nettype none

module pwm_duty_capture_averager #(
  parameter int unsigned AVG_LOG2   = pdca_pkg::AVG_LOG2_DEF,
  parameter int unsigned COUNT_BITS = pdca_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pdca_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pdca_pkg::out_item_t                    out_data,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pdca_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pdca_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pdca_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned FW = pdca_pkg::FIELD_W;

  pdca_pkg::cmd_t      cmd;
  pdca_pkg::stat_t     stat;
  pdca_pkg::out_item_t result;

  logic [FW-1:0]       full_scale_r;
  logic                out_valid_r;
  pdca_pkg::out_item_t out_data_r;
  logic                out_free;
  logic                reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == pdca_pkg::REG_FULL_SCALE);
  assign prdata  = reg_hit ? pdca_pkg::APB_DATA_W'(full_scale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= pdca_pkg::FULL_SCALE_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      full_scale_r <= pwdata[FW-1:0];
    end
  end

  // output register: free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= result;
    end
  end

  pdca_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .out_free (out_free),
    .cmd      (cmd)
  );

  pdca_dp #(
    .AVG_LOG2   (AVG_LOG2),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_data),
    .full_scale (full_scale_r),
    .stat       (stat),
    .result     (result)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a held, stalled result");

endmodule

`default_nettype wire
